// ===== rtl/exception_frame_stack_search_core_defines.svh =====
// ----------------------------------------------------------------------------
// exception frame stack search: assertion macros
// shared concurrent check forms, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef EXCEPTION_FRAME_STACK_SEARCH_CORE_DEFINES_SVH
`define EXCEPTION_FRAME_STACK_SEARCH_CORE_DEFINES_SVH

// condition in the same cycle
`define EFSS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efss check failed");

// condition in the following cycle
`define EFSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efss check failed");

`endif

// ===== rtl/efss_pkg.sv =====
// ----------------------------------------------------------------------------
// efss_pkg
// types and constants of the exception frame stack search block
// ----------------------------------------------------------------------------
package efss_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KIND_BITS     = 8;
    // stored kind width, the kind fields on the ports are 8 bits
    localparam int KIND_W        = (KIND_BITS < 8) ? KIND_BITS : 8;

    typedef enum logic [1:0] {
        CMD_PUSH       = 2'd0,
        CMD_POP        = 2'd1,
        CMD_FIND_CATCH = 2'd2,
        CMD_FIND_ANY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] try_begin;
        logic [31:0] try_end;
        logic [31:0] handler_entry;
        logic [31:0] handler_last;
        logic [31:0] filter_entry;
        logic [7:0]  catch_kind;
        logic [31:0] catch_index;
        logic [31:0] fault_pc;
        logic [7:0]  fault_kind;
        logic [31:0] fault_index;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  frame_level;
        logic [31:0] hit_try_begin;
        logic [31:0] hit_try_end;
        logic [31:0] hit_handler_entry;
        logic [31:0] hit_handler_last;
        logic [31:0] hit_filter_entry;
        logic [7:0]  hit_catch_kind;
        logic [31:0] hit_catch_index;
        logic [4:0]  stack_count;
        status_t     status;
    } rsp_t;

    typedef struct packed {
        logic [31:0]       try_begin;
        logic [31:0]       try_end;
        logic [31:0]       handler_entry;
        logic [31:0]       handler_last;
        logic [31:0]       filter_entry;
        logic [KIND_W-1:0] catch_kind;
        logic [31:0]       catch_index;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

endpackage

// ===== rtl/efss_ram.sv =====
// ----------------------------------------------------------------------------
// efss_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module efss_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/efss_match.sv =====
// ----------------------------------------------------------------------------
// efss_match
// compares one stored frame against the fault pc, kind and index
// ----------------------------------------------------------------------------
module efss_match (
    input  efss_pkg::frame_t                frame,
    input  logic [31:0]                     pc,
    input  logic [efss_pkg::KIND_W-1:0]     kind,
    input  logic [31:0]                     index,
    input  logic                            any_mode,
    output logic                            hit
);
    import efss_pkg::*;

    logic covers;
    logic kind_ok;
    logic index_ok;

    // half-open range, an empty or inverted range never covers
    assign covers   = (pc >= frame.try_begin) && (pc < frame.try_end);
    assign kind_ok  = (frame.catch_kind == '0) || (frame.catch_kind == kind);
    assign index_ok = (frame.catch_index == '0) || (frame.catch_index == index);
    assign hit      = covers && (any_mode || (kind_ok && index_ok));

endmodule

// ===== rtl/exception_frame_stack_search_core.sv =====
// ----------------------------------------------------------------------------
// exception_frame_stack_search_core
// bounded stack of protected-region frames with top-down handler search
// ----------------------------------------------------------------------------
//
//  channel  ports                       payload  direction
//  req      req_valid / req_stall       req_t    into the block
//  rsp      rsp_valid / rsp_stall       rsp_t    out of the block
//
//  one request at a time; an accepted request is registered and then run in
//  EXEC, where push and pop act on the stack, and a find goes on to SEARCH,
//  visiting at most STACK_DEPTH frames through the single read port of the
//  frame ram, which yields one frame per cycle from the top down. FINISH
//  loads the response once the output register is free and returns to IDLE,
//  where the next request is taken. reset clears the state, the frame
//  count and rsp_valid, the frame ram holds no reset value. a stalled
//  response waits in the output register while the next request is taken and worked on.
//
`include "exception_frame_stack_search_core_defines.svh"

module exception_frame_stack_search_core #(
    parameter int STACK_DEPTH = efss_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  efss_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output efss_pkg::rsp_t  rsp
);
    import efss_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        IDLE,
        EXEC,
        SEARCH,
        FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    req_t            req_reg;
    rsp_t            pend_reg, pend_next;
    rsp_t            rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    logic            accept;
    logic            rsp_free;
    logic            full;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    frame_t          wr_frame;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    frame_t          rd_frame;
    logic            hit;

    efss_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STACK_DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_frame),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_frame)
    );

    efss_match u_match (
        .frame    (rd_frame),
        .pc       (req_reg.fault_pc),
        .kind     (req_reg.fault_kind[KIND_W-1:0]),
        .index    (req_reg.fault_index),
        .any_mode (req_reg.command == CMD_FIND_ANY),
        .hit      (hit)
    );

    assign accept    = req_valid && (state_reg == IDLE);
    assign req_stall = (state_reg != IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign wr_addr                = AW'(count_reg);
    assign wr_frame.try_begin     = req_reg.try_begin;
    assign wr_frame.try_end       = req_reg.try_end;
    assign wr_frame.handler_entry = req_reg.handler_entry;
    assign wr_frame.handler_last  = req_reg.handler_last;
    assign wr_frame.filter_entry  = req_reg.filter_entry;
    assign wr_frame.catch_kind    = req_reg.catch_kind[KIND_W-1:0];
    assign wr_frame.catch_index   = req_reg.catch_index;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;

        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                pend_next  = '0;
                state_next = FINISH;
                case (req_reg.command)
                    CMD_PUSH:
                    begin
                        if (full)
                        begin
                            pend_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            pend_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    default:
                    begin
                        // start the search at the top frame
                        if (count_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(count_reg - CW'(1));
                            ptr_next   = AW'(count_reg - CW'(1));
                            state_next = SEARCH;
                        end
                    end
                endcase
            end
            SEARCH:
            begin
                if (hit)
                begin
                    pend_next                   = '0;
                    pend_next.found             = 1'b1;
                    pend_next.frame_level       = 4'(ptr_reg);
                    pend_next.hit_try_begin     = rd_frame.try_begin;
                    pend_next.hit_try_end       = rd_frame.try_end;
                    pend_next.hit_handler_entry = rd_frame.handler_entry;
                    pend_next.hit_handler_last  = rd_frame.handler_last;
                    pend_next.hit_filter_entry  = rd_frame.filter_entry;
                    pend_next.hit_catch_kind    = 8'(rd_frame.catch_kind);
                    pend_next.hit_catch_index   = rd_frame.catch_index;
                    state_next                  = FINISH;
                end
                else if (ptr_reg == '0)
                begin
                    pend_next  = '0;
                    state_next = FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - AW'(1);
                    ptr_next = ptr_reg - AW'(1);
                end
            end
            FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_next             = pend_reg;
                    rsp_next.stack_count = 5'(count_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        ptr_reg  <= ptr_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    `EFSS_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CW'(STACK_DEPTH))
    `EFSS_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state_reg == EXEC)
    `EFSS_ASSERT_IMPLY(a_search_in_stack, state_reg == SEARCH, CW'(ptr_reg) < count_reg)
    `EFSS_ASSERT_IMPLY(a_full_drop, rsp_valid && rsp.status == ST_FULL, rsp.stack_count == 5'(STACK_DEPTH))
    `EFSS_ASSERT_IMPLY(a_miss_blank, rsp_valid && !rsp.found, rsp.frame_level == 4'd0 && rsp.hit_try_begin == 32'd0)

endmodule

// ===== tb/sv/exception_frame_stack_search_core_test.sv =====
// ----------------------------------------------------------------------------
// exception_frame_stack_search_core_test
// checks the frame stack and its top-down handler search: each accepted
// request updates a scoreboard that keeps its own copy of the stack and
// predicts the response, then every response is compared field by field
// ----------------------------------------------------------------------------
module exception_frame_stack_search_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import efss_pkg::*;

    localparam int STACK_DEPTH     = DEPTH_DEFAULT;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int DRAIN_CYCLES    = STACK_DEPTH + 8;

    class frame_search_scoreboard;
        frame_t frames[STACK_DEPTH];
        int     depth;
        rsp_t   expected_q[$];
        int     mismatch_count;

        function new();
            depth          = 0;
            mismatch_count = 0;
        endfunction

        function rsp_t predict_response(req_t r);
            rsp_t   e;
            frame_t f;
            e = '0;
            e.status = ST_OK;
            case (r.command)
                CMD_PUSH:
                begin
                    if (depth < STACK_DEPTH)
                    begin
                        f.try_begin     = r.try_begin;
                        f.try_end       = r.try_end;
                        f.handler_entry = r.handler_entry;
                        f.handler_last  = r.handler_last;
                        f.filter_entry  = r.filter_entry;
                        f.catch_kind    = r.catch_kind[KIND_W-1:0];
                        f.catch_index   = r.catch_index;
                        frames[depth]   = f;
                        depth++;
                    end
                    else
                    begin
                        e.status = ST_FULL;
                    end
                end
                CMD_POP:
                begin
                    if (depth > 0)
                        depth--;
                    else
                        e.status = ST_EMPTY;
                end
                default:
                begin
                    // walk from the top frame down, first hit wins
                    for (int lvl = depth - 1; lvl >= 0; lvl--)
                    begin
                        f = frames[lvl];
                        if (r.fault_pc >= f.try_begin && r.fault_pc < f.try_end &&
                            (r.command == CMD_FIND_ANY ||
                             ((f.catch_kind == '0 ||
                               f.catch_kind == r.fault_kind[KIND_W-1:0]) &&
                              (f.catch_index == '0 || f.catch_index == r.fault_index))))
                        begin
                            e.found             = 1'b1;
                            e.frame_level       = 4'(lvl);
                            e.hit_try_begin     = f.try_begin;
                            e.hit_try_end       = f.try_end;
                            e.hit_handler_entry = f.handler_entry;
                            e.hit_handler_last  = f.handler_last;
                            e.hit_filter_entry  = f.filter_entry;
                            e.hit_catch_kind    = 8'(f.catch_kind);
                            e.hit_catch_index   = f.catch_index;
                            break;
                        end
                    end
                end
            endcase
            e.stack_count = 5'(depth);
            return e;
        endfunction

        function void note_request(req_t r);
            expected_q.push_back(predict_response(r));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: response with nothing outstanding, expected none got %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("found", want.found, got.found);
            compare_field("frame_level", want.frame_level, got.frame_level);
            compare_field("hit_try_begin", want.hit_try_begin, got.hit_try_begin);
            compare_field("hit_try_end", want.hit_try_end, got.hit_try_end);
            compare_field("hit_handler_entry", want.hit_handler_entry, got.hit_handler_entry);
            compare_field("hit_handler_last", want.hit_handler_last, got.hit_handler_last);
            compare_field("hit_filter_entry", want.hit_filter_entry, got.hit_filter_entry);
            compare_field("hit_catch_kind", want.hit_catch_kind, got.hit_catch_kind);
            compare_field("hit_catch_index", want.hit_catch_index, got.hit_catch_index);
            compare_field("stack_count", want.stack_count, got.stack_count);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    bit   quiet      = 1'b0;
    int   stall_left = 0;

    frame_search_scoreboard stack_sb = new();

    exception_frame_stack_search_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // response backpressure, mostly short bursts with a few long ones
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < 30)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 2);
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            stack_sb.check_response(rsp);
    end

    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_kind();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1, 2:    return 8'($urandom_range(1, 3));
            3:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_index();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1, 2:    return 32'($urandom_range(1, 3));
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // every field random, the command decides which of them matter
    function automatic req_t random_base(cmd_t c);
        req_t r;
        r.command       = c;
        r.try_begin     = $urandom;
        r.try_end       = $urandom;
        r.handler_entry = $urandom;
        r.handler_last  = $urandom;
        r.filter_entry  = $urandom;
        r.catch_kind    = 8'($urandom);
        r.catch_index   = $urandom;
        r.fault_pc      = $urandom;
        r.fault_kind    = 8'($urandom);
        r.fault_index   = $urandom;
        return r;
    endfunction

    function automatic req_t make_push(logic [31:0] ts, logic [31:0] te, logic [31:0] hs,
                                       logic [31:0] he, logic [31:0] fs, logic [7:0] kind,
                                       logic [31:0] idx);
        req_t r;
        r               = random_base(CMD_PUSH);
        r.try_begin     = ts;
        r.try_end       = te;
        r.handler_entry = hs;
        r.handler_last  = he;
        r.filter_entry  = fs;
        r.catch_kind    = kind;
        r.catch_index   = idx;
        return r;
    endfunction

    function automatic req_t make_find(cmd_t c, logic [31:0] pc, logic [7:0] kind,
                                       logic [31:0] idx);
        req_t r;
        r             = random_base(c);
        r.fault_pc    = pc;
        r.fault_kind  = kind;
        r.fault_index = idx;
        return r;
    endfunction

    function automatic req_t random_push();
        logic [31:0] ts;
        logic [31:0] te;
        int          roll;
        roll = $urandom_range(0, 9);
        ts   = 32'($urandom_range(0, 63) * 16);
        if (roll < 7)
        begin
            te = ts + 32'($urandom_range(1, 96));
        end
        else if (roll == 7)
        begin
            te = ts;
        end
        else if (roll == 8)
        begin
            te = ts - 32'($urandom_range(1, 32));
        end
        else
        begin
            ts = $urandom;
            te = ($urandom_range(0, 1) == 0) ? 32'hffff_ffff : $urandom;
        end
        return make_push(ts, te, $urandom, $urandom, $urandom, pick_kind(), pick_index());
    endfunction

    function automatic req_t random_find(cmd_t c);
        frame_t      f;
        logic [31:0] pc;
        logic [31:0] span;
        logic [7:0]  kind;
        logic [31:0] idx;
        pc   = 32'($urandom_range(0, 1100));
        kind = pick_kind();
        idx  = pick_index();
        if (stack_sb.depth > 0 && $urandom_range(0, 9) < 8)
        begin
            // aim at a stored frame, often right on its edges
            f    = stack_sb.frames[$urandom_range(0, stack_sb.depth - 1)];
            span = f.try_end - f.try_begin;
            case ($urandom_range(0, 7))
                0:       pc = f.try_begin;
                1:       pc = f.try_end - 1;
                2:       pc = f.try_end;
                3:       pc = f.try_begin - 1;
                default: pc = (f.try_end > f.try_begin) ? f.try_begin + ($urandom % span)
                                                        : f.try_begin;
            endcase
            if ($urandom_range(0, 2) != 0)
                kind = 8'(f.catch_kind);
            if ($urandom_range(0, 2) != 0)
                idx = f.catch_index;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            pc = $urandom;
        end
        return make_find(c, pc, kind, idx);
    endfunction

    task automatic send_request(req_t r);
        int gap;
        gap = gap_cycles();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        stack_sb.note_request(r);
    endtask

    initial
    begin
        req_t directed_q[$];
        int   mode;
        int   mode_left;
        int   roll;
        int   push_pct;
        int   pop_pct;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty stack cases, then wildcard, exact, empty and inverted ranges
        directed_q.push_back(random_base(CMD_POP));
        directed_q.push_back(make_find(CMD_FIND_CATCH, 32'd150, 8'h00, 32'h0));
        directed_q.push_back(make_find(CMD_FIND_ANY, 32'd150, 8'h00, 32'h0));
        directed_q.push_back(make_push(32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff,
                                       32'hffff_ffff, 8'h00, 32'h0));
        directed_q.push_back(make_push(32'd100, 32'd200, 32'h1000, 32'h1fff,
                                       32'h0, 8'hff, 32'hffff_ffff));
        directed_q.push_back(make_push(32'd300, 32'd300, 32'h2000, 32'h2100,
                                       32'h2200, 8'h00, 32'h0));
        directed_q.push_back(make_push(32'd500, 32'd400, 32'h3000, 32'h3100,
                                       32'h3200, 8'h00, 32'h0));
        directed_q.push_back(make_find(CMD_FIND_CATCH, 32'd150, 8'hff, 32'hffff_ffff));
        directed_q.push_back(make_find(CMD_FIND_CATCH, 32'd150, 8'h01, 32'hffff_ffff));
        directed_q.push_back(make_find(CMD_FIND_CATCH, 32'd200, 8'hff, 32'hffff_ffff));
        directed_q.push_back(make_find(CMD_FIND_ANY, 32'd300, 8'h00, 32'h0));
        directed_q.push_back(make_find(CMD_FIND_ANY, 32'd450, 8'h00, 32'h0));
        directed_q.push_back(make_find(CMD_FIND_ANY, 32'hffff_ffff, 8'hff, 32'hffff_ffff));
        directed_q.push_back(make_find(CMD_FIND_ANY, 32'h0, 8'h00, 32'h0));
        directed_q.push_back(make_push(32'h10, 32'h20, 32'h4000, 32'h4100,
                                       32'h4200, 8'h05, 32'h0));
        directed_q.push_back(make_find(CMD_FIND_CATCH, 32'h10, 8'h05, 32'd12345));
        directed_q.push_back(make_find(CMD_FIND_CATCH, 32'h1f, 8'h06, 32'd12345));
        directed_q.push_back(make_find(CMD_FIND_CATCH, 32'd150, 8'hff, 32'hffff_fffe));
        directed_q.push_back(random_base(CMD_POP));
        directed_q.push_back(make_find(CMD_FIND_ANY, 32'h10, 8'h00, 32'h0));
        directed_q.push_back(random_base(CMD_POP));
        foreach (directed_q[i])
            send_request(directed_q[i]);

        // random phases: filling toward full, draining toward empty, or mixed
        mode      = 0;
        mode_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 60);
                quiet     = ($urandom_range(0, 3) == 0);
            end
            mode_left--;
            case (mode)
                0:       begin push_pct = 50; pop_pct = 10; end
                1:       begin push_pct = 10; pop_pct = 50; end
                default: begin push_pct = 25; pop_pct = 20; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                send_request(random_push());
            else if (roll < push_pct + pop_pct)
                send_request(random_base(CMD_POP));
            else if (roll < push_pct + pop_pct + 25)
                send_request(random_find(CMD_FIND_CATCH));
            else
                send_request(random_find(CMD_FIND_ANY));
        end
        req_valid <= 1'b0;
        quiet     = 1'b0;

        while (stack_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (stack_sb.mismatch_count == 0 && stack_sb.expected_q.size() == 0)
            $display("exception_frame_stack_search_core_test passed");
        else
            $display("exception_frame_stack_search_core_test failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("exception_frame_stack_search_core_test failed");
        $finish;
    end

endmodule
